@@ rtl/sct_pkg.sv @@
package sct_pkg;

  // Request codes on req_type_i
  typedef enum logic [2:0] {
    REQ_ENTER  = 3'd0,
    REQ_EXIT   = 3'd1,
    REQ_JOG    = 3'd2,
    REQ_SET    = 3'd3,
    REQ_ADD    = 3'd4,
    REQ_DELETE = 3'd5,
    REQ_CLEAR  = 3'd6,
    REQ_READ   = 3'd7
  } req_e;

  // Operation broadcast to every cell of the row in its update cycle
  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_ADD  = 2'd1,
    CELL_DEL  = 2'd2
  } cell_op_e;

  // One table entry
  typedef struct packed {
    logic signed [15:0] temp;
    logic        [15:0] duty;
  } entry_t;

  // Broadcast control from the sequencer to the cell row
  typedef struct packed {
    cell_op_e op;
    logic     upd;  // add hits an existing temperature: rewrite its duty
    logic     ins;  // add inserts a new entry
  } cell_ctrl_t;

endpackage

@@ rtl/sct_cell.sv @@
module sct_cell (
  input  logic                clk_i,
  input  sct_pkg::cell_ctrl_t ctrl_i,
  input  sct_pkg::entry_t     new_i,
  input  logic                valid_i,
  input  logic                at_tail_i,
  input  logic                del_sel_i,
  input  sct_pkg::entry_t     left_i,
  input  logic                left_gt_i,
  input  sct_pkg::entry_t     right_i,
  output sct_pkg::entry_t     entry_o,
  output logic                gt_o,
  output logic                eq_o
);

  sct_pkg::entry_t entry_q, entry_d;

  // Compare the stored key against the broadcast key
  assign gt_o = valid_i && (entry_q.temp > new_i.temp);
  assign eq_o = valid_i && (entry_q.temp == new_i.temp);
  assign entry_o = entry_q;

  // Update: rewrite duty on a hit, shift up on insert, shift down on delete
  always_comb begin
    entry_d = entry_q;
    case (ctrl_i.op)
      sct_pkg::CELL_ADD: begin
        if (ctrl_i.upd && eq_o) begin
          entry_d.duty = new_i.duty;
        end else if (ctrl_i.ins && (gt_o || at_tail_i)) begin
          entry_d = left_gt_i ? left_i : new_i;
        end
      end
      sct_pkg::CELL_DEL: begin
        if (del_sel_i) begin
          entry_d = right_i;
        end
      end
      default: begin
        entry_d = entry_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

@@ rtl/sorted_calibration_table_unit.sv @@
// Result: an accepted item waits in ST_EXEC, and out_valid_o rises as it leaves,
// as long as no earlier result is still waiting.
// Requests: a new item is taken only in ST_IDLE, once the last has left ST_EXEC;
// the row of cells performs a whole search, insert, update or delete in its update cycle.
// Reset: count, duty and calibration mode clear, max_duty returns to 4095;
// table contents are not cleared and are read only after being written.
module sorted_calibration_table_unit #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         req_type_i,
  input  logic signed [16:0] duty_delta_i,
  input  logic signed [16:0] duty_value_i,
  input  logic signed [15:0] temperature_i,
  input  logic [7:0]         entry_index_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               status_o,
  output logic               cal_mode_o,
  output logic [15:0]        current_duty_o,
  output logic [4:0]         point_count_o,
  output logic               point_valid_o,
  output logic signed [15:0] point_temp_o,
  output logic [15:0]        point_duty_o
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int IW = $clog2(TABLE_DEPTH);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e state_q;

  logic [15:0]        max_q;
  logic [CW-1:0]      count_q, count_d;
  logic [15:0]        duty_q, duty_d;
  logic               mode_q, mode_d;

  sct_pkg::req_e      req_q;
  logic signed [16:0] delta_q;
  logic signed [16:0] dval_q;
  logic signed [15:0] temp_q;
  logic [7:0]         idx_q;

  logic               out_valid_q;
  logic               status_q;
  logic               pvalid_q;
  sct_pkg::entry_t    pent_q;

  sct_pkg::entry_t    ent [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] gt_vec, eq_vec, valid_vec, tail_vec, dsel_vec;

  sct_pkg::cell_ctrl_t ctrl;
  sct_pkg::entry_t     new_ent;
  sct_pkg::entry_t     rd_ent;

  logic               step;
  logic               any_eq;
  logic               is_full;
  logic               idx_ok;
  logic signed [17:0] jog_sum;
  logic               status_d;
  logic               pvalid_d;
  sct_pkg::entry_t    pent_d;
  logic [31:0]        count_ext;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign step        = (state_q == ST_EXEC) && (!out_valid_q || out_ready_i);

  assign any_eq  = |eq_vec;
  assign is_full = (32'(count_q) >= TABLE_DEPTH);
  assign idx_ok  = (9'({1'b0, idx_q}) < 9'(count_q));
  assign new_ent = '{temp: temp_q, duty: duty_q};
  assign rd_ent  = ent[idx_q[IW-1:0]];
  assign jog_sum = $signed({2'b00, duty_q}) + 18'(delta_q);

  // Row of cells, each shifting from its left or right neighbor
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    sct_pkg::entry_t left_ent;
    sct_pkg::entry_t right_ent;
    logic            left_gt;

    assign valid_vec[i] = (32'(count_q) > 32'(i));
    assign tail_vec[i]  = (32'(count_q) == 32'(i));
    assign dsel_vec[i]  = (32'(i) >= 32'(idx_q));

    if (i == 0) begin : g_first
      assign left_ent = '0;
      assign left_gt  = 1'b0;
    end else begin : g_inner
      assign left_ent = ent[i-1];
      assign left_gt  = gt_vec[i-1];
    end

    if (i == TABLE_DEPTH - 1) begin : g_last
      assign right_ent = ent[i];
    end else begin : g_mid
      assign right_ent = ent[i+1];
    end

    sct_cell u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (ctrl),
      .new_i     (new_ent),
      .valid_i   (valid_vec[i]),
      .at_tail_i (tail_vec[i]),
      .del_sel_i (dsel_vec[i]),
      .left_i    (left_ent),
      .left_gt_i (left_gt),
      .right_i   (right_ent),
      .entry_o   (ent[i]),
      .gt_o      (gt_vec[i]),
      .eq_o      (eq_vec[i])
    );
  end

  // Decode the held item into cell control and next state
  always_comb begin
    ctrl     = '{op: sct_pkg::CELL_HOLD, upd: 1'b0, ins: 1'b0};
    count_d  = count_q;
    duty_d   = duty_q;
    mode_d   = mode_q;
    status_d = 1'b0;
    pvalid_d = 1'b0;
    pent_d   = '0;
    case (req_q)
      sct_pkg::REQ_ENTER: begin
        mode_d = 1'b1;
      end
      sct_pkg::REQ_EXIT: begin
        mode_d = 1'b0;
      end
      sct_pkg::REQ_JOG: begin
        mode_d = 1'b1;
        if (jog_sum[17]) begin
          duty_d = '0;
        end else if (jog_sum[16:0] > {1'b0, max_q}) begin
          duty_d = max_q;
        end else begin
          duty_d = jog_sum[15:0];
        end
      end
      sct_pkg::REQ_SET: begin
        mode_d = 1'b1;
        if (dval_q[16]) begin
          duty_d = '0;
        end else if (dval_q[15:0] > max_q) begin
          duty_d = max_q;
        end else begin
          duty_d = dval_q[15:0];
        end
      end
      sct_pkg::REQ_ADD: begin
        ctrl.op  = sct_pkg::CELL_ADD;
        ctrl.upd = any_eq;
        ctrl.ins = !any_eq && !is_full;
        status_d = !any_eq && is_full;
        if (ctrl.ins) begin
          count_d = count_q + CW'(1);
        end
      end
      sct_pkg::REQ_DELETE: begin
        if (idx_ok) begin
          ctrl.op = sct_pkg::CELL_DEL;
          count_d = count_q - CW'(1);
        end
      end
      sct_pkg::REQ_CLEAR: begin
        count_d = '0;
      end
      sct_pkg::REQ_READ: begin
        if (idx_ok) begin
          pvalid_d = 1'b1;
          pent_d   = rd_ent;
        end
      end
      default: begin
        ctrl = '{op: sct_pkg::CELL_HOLD, upd: 1'b0, ins: 1'b0};
      end
    endcase
    if (!step) begin
      ctrl.op = sct_pkg::CELL_HOLD;
    end
  end

  // Hold state, sequencer and registered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      max_q       <= 16'd4095;
      count_q     <= '0;
      duty_q      <= '0;
      mode_q      <= 1'b0;
      out_valid_q <= 1'b0;
      status_q    <= 1'b0;
      pvalid_q    <= 1'b0;
      pent_q      <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        max_q <= cfg_data_i;
      end
      if (out_valid_q && out_ready_i && !step) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (step) begin
            state_q     <= ST_IDLE;
            count_q     <= count_d;
            duty_q      <= duty_d;
            mode_q      <= mode_d;
            out_valid_q <= 1'b1;
            status_q    <= status_d;
            pvalid_q    <= pvalid_d;
            pent_q      <= pent_d;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Capture item fields
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_q   <= sct_pkg::req_e'(req_type_i);
      delta_q <= duty_delta_i;
      dval_q  <= duty_value_i;
      temp_q  <= temperature_i;
      idx_q   <= entry_index_i;
    end
  end

  assign count_ext      = 32'(count_q);
  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign cal_mode_o     = mode_q;
  assign current_duty_o = duty_q;
  assign point_count_o  = count_ext[4:0];
  assign point_valid_o  = pvalid_q;
  assign point_temp_o   = pent_q.temp;
  assign point_duty_o   = pent_q.duty;

  // Count never exceeds the table depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= TABLE_DEPTH)
    else $error("entry count above table depth");

  // An accepted item moves the sequencer to its update cycle
  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_EXEC))
    else $error("accepted item not executed");

  // Table full is reported only when the table is full
  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o) |-> is_full)
    else $error("table full reported with free entries");

  // A waiting result item holds until it is taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o &&
      $stable({status_o, cal_mode_o, current_duty_o, point_count_o,
               point_valid_o, point_temp_o, point_duty_o})))
    else $error("result changed while waiting");

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps

module tb;

  localparam int DEPTH = 16;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int LONG_HOLD = 80;
  localparam int PHASE_ITEMS = 130;
  localparam int DIR_ROWS = 25;

  // One request item as offered on the input channel
  typedef struct packed {
    sct_pkg::req_e      req;
    logic signed [16:0] delta;
    logic signed [16:0] value;
    logic signed [15:0] temp;
    logic [7:0]         idx;
  } cal_request_t;

  // One result item as seen on the output channel
  typedef struct packed {
    logic               status;
    logic               mode;
    logic [15:0]        duty;
    logic [4:0]         count;
    logic               pvalid;
    logic signed [15:0] ptemp;
    logic [15:0]        pduty;
  } cal_result_t;

  // Stimulus row: request plus an optional hand-written expected result
  typedef struct packed {
    cal_request_t rq;
    logic         typed;
    cal_result_t  res;
  } stim_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [15:0]        cfg_data = 16'd0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [2:0]         req_type = 3'd0;
  logic signed [16:0] duty_delta = 17'sd0;
  logic signed [16:0] duty_value = 17'sd0;
  logic signed [15:0] temperature = 16'sd0;
  logic [7:0]         entry_index = 8'd0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               status;
  logic               cal_mode;
  logic [15:0]        current_duty;
  logic [4:0]         point_count;
  logic               point_valid;
  logic signed [15:0] point_temp;
  logic [15:0]        point_duty;

  // Predicted block state
  logic signed [15:0] pred_temps [DEPTH];
  logic [15:0]        pred_duties [DEPTH];
  int                 pred_count = 0;
  logic [15:0]        pred_duty = 16'd0;
  logic               pred_mode = 1'b0;
  logic [15:0]        pred_cap = 16'd4095;

  cal_result_t cal_results_due [$];
  stim_row_t   batch [$];
  stim_row_t   dir_rows [DIR_ROWS];
  int          err_count = 0;
  int          quiet_cycles = 0;
  logic        send_gaps = 1'b1;
  logic        take_gaps = 1'b1;
  logic        hold_out = 1'b0;

  sorted_calibration_table_unit #(
    .TABLE_DEPTH(DEPTH)
  ) dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .req_type_i    (req_type),
    .duty_delta_i  (duty_delta),
    .duty_value_i  (duty_value),
    .temperature_i (temperature),
    .entry_index_i (entry_index),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .status_o      (status),
    .cal_mode_o    (cal_mode),
    .current_duty_o(current_duty),
    .point_count_o (point_count),
    .point_valid_o (point_valid),
    .point_temp_o  (point_temp),
    .point_duty_o  (point_duty)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [15:0] clamp_duty(longint d);
    if (d < 0) return 16'd0;
    if (d > longint'(pred_cap)) return pred_cap;
    return d[15:0];
  endfunction

  // Apply one request to the predicted state and return the result it yields
  function automatic cal_result_t run_cal_request(cal_request_t rq);
    cal_result_t r;
    int          pos;
    logic        hit;
    r = '0;
    pos = 0;
    hit = 1'b0;
    case (rq.req)
      sct_pkg::REQ_ENTER: pred_mode = 1'b1;
      sct_pkg::REQ_EXIT:  pred_mode = 1'b0;
      sct_pkg::REQ_JOG: begin
        pred_duty = clamp_duty(longint'(pred_duty) + longint'($signed(rq.delta)));
        pred_mode = 1'b1;
      end
      sct_pkg::REQ_SET: begin
        pred_duty = clamp_duty(longint'($signed(rq.value)));
        pred_mode = 1'b1;
      end
      sct_pkg::REQ_ADD: begin
        // update in place on a known temperature, full or not
        for (int i = 0; i < pred_count; i++) begin
          if (pred_temps[i] == rq.temp) begin
            pred_duties[i] = pred_duty;
            hit = 1'b1;
          end
        end
        if (!hit && pred_count >= DEPTH) begin
          r.status = 1'b1;
        end else if (!hit) begin
          while (pos < pred_count && $signed(pred_temps[pos]) < $signed(rq.temp)) pos++;
          for (int i = pred_count; i > pos; i--) begin
            pred_temps[i] = pred_temps[i - 1];
            pred_duties[i] = pred_duties[i - 1];
          end
          pred_temps[pos] = rq.temp;
          pred_duties[pos] = pred_duty;
          pred_count++;
        end
      end
      sct_pkg::REQ_DELETE: begin
        // drop the entry and close the gap; out of range is ignored
        if (int'(rq.idx) < pred_count) begin
          for (int i = int'(rq.idx); i + 1 < pred_count; i++) begin
            pred_temps[i] = pred_temps[i + 1];
            pred_duties[i] = pred_duties[i + 1];
          end
          pred_count--;
        end
      end
      sct_pkg::REQ_CLEAR: pred_count = 0;
      default: begin
        if (int'(rq.idx) < pred_count) begin
          r.pvalid = 1'b1;
          r.ptemp = pred_temps[rq.idx];
          r.pduty = pred_duties[rq.idx];
        end
      end
    endcase
    r.mode = pred_mode;
    r.duty = pred_duty;
    r.count = 5'(pred_count);
    return r;
  endfunction

  task automatic note_error(string msg);
    err_count++;
    if (err_count <= 10) $display("%s", msg);
  endtask

  // Offer every queued item in order, predicting each one as it goes out
  task automatic drive_batch();
    stim_row_t   row;
    cal_result_t want;
    int          gap;
    while (batch.size() != 0) begin
      row = batch.pop_front();
      gap = send_gaps ? $urandom_range(0, 7) : 0;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid <= 1'b1;
      req_type <= row.rq.req;
      duty_delta <= row.rq.delta;
      duty_value <= row.rq.value;
      temperature <= row.rq.temp;
      entry_index <= row.rq.idx;
      want = run_cal_request(row.rq);
      if (row.typed) want = row.res;
      cal_results_due.push_back(want);
      @(posedge clk);
      while (!in_ready) @(posedge clk);
    end
    in_valid <= 1'b0;
  endtask

  // Write the duty clamp once the block has drained
  task automatic write_max_duty(logic [15:0] cap);
    while (cal_results_due.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= cap;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    pred_cap = cap;
  endtask

  // Clear, fill to full, overflow, update on full, then a random mix
  task automatic plan_random(int n);
    stim_row_t row;
    int        pick;
    int        base;
    base = int'($urandom_range(0, 2000)) - 1000;
    for (int k = 0; k < n; k++) begin
      row = '0;
      row.rq.delta = ($urandom_range(0, 1) != 0) ? 17'($urandom)
                                                 : 17'(int'($urandom_range(0, 2000)) - 1000);
      row.rq.value = ($urandom_range(0, 1) != 0) ? 17'($urandom)
                                                 : 17'(int'($urandom_range(0, 5000)) - 500);
      pick = $urandom_range(0, 9);
      if (pick < 7) row.rq.temp = 16'(int'($urandom_range(0, 24)) - 12);
      else if (pick < 8) row.rq.temp = ($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000;
      else row.rq.temp = 16'($urandom);
      row.rq.idx = ($urandom_range(0, 4) != 0) ? 8'($urandom_range(0, 17)) : 8'($urandom);
      if (k == 0) begin
        row.rq.req = sct_pkg::REQ_CLEAR;
      end else if (k <= DEPTH + 1) begin
        row.rq.req = sct_pkg::REQ_ADD;
        row.rq.temp = 16'(base + ((k * 7) % (DEPTH + 1)) * 13);
      end else if (k == DEPTH + 2) begin
        row.rq.req = sct_pkg::REQ_ADD;
        row.rq.temp = 16'(base + 13 * 3);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 45)      row.rq.req = sct_pkg::REQ_ADD;
        else if (pick < 60) row.rq.req = sct_pkg::REQ_READ;
        else if (pick < 68) row.rq.req = sct_pkg::REQ_DELETE;
        else if (pick < 70) row.rq.req = sct_pkg::REQ_CLEAR;
        else if (pick < 80) row.rq.req = sct_pkg::REQ_JOG;
        else if (pick < 88) row.rq.req = sct_pkg::REQ_SET;
        else if (pick < 94) row.rq.req = sct_pkg::REQ_ENTER;
        else                row.rq.req = sct_pkg::REQ_EXIT;
      end
      batch.push_back(row);
    end
  endtask

  // Take results, with a per-item stall and one long hold-off
  initial begin
    int stall;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_out) begin
        hold_out = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        stall = take_gaps ? $urandom_range(0, 7) : 0;
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Compare each result item against the oldest prediction
  always @(posedge clk) begin
    cal_result_t want;
    if (out_valid && out_ready) begin
      if (cal_results_due.size() == 0) begin
        note_error($sformatf("tb: result with no item pending, duty=%0d cnt=%0d",
                             current_duty, point_count));
      end else begin
        want = cal_results_due.pop_front();
        if (status !== want.status || cal_mode !== want.mode ||
            current_duty !== want.duty || point_count !== want.count ||
            point_valid !== want.pvalid || point_temp !== want.ptemp ||
            point_duty !== want.pduty)
          note_error($sformatf({"tb: mismatch exp st=%0d md=%0d duty=%0d cnt=%0d",
                                " pv=%0d pt=%0d pd=%0d / got st=%0d md=%0d duty=%0d",
                                " cnt=%0d pv=%0d pt=%0d pd=%0d"},
                               want.status, want.mode, want.duty, want.count,
                               want.pvalid, want.ptemp, want.pduty,
                               status, cal_mode, current_duty, point_count,
                               point_valid, point_temp, point_duty));
      end
    end
  end

  // End the run when no channel has moved for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [15:0] caps [6];
    caps = '{16'd0, 16'hffff, 16'($urandom), 16'd1, 16'd4095,
             16'($urandom_range(100, 5000))};

    // Directed rows run with the reset clamp of 4095
    dir_rows[0]  = '{'{sct_pkg::REQ_READ, 17'sd0, 17'sd0, 16'sd0, 8'd0}, 1'b1,
                     '{1'b0, 1'b0, 16'd0, 5'd0, 1'b0, 16'sd0, 16'd0}};
    dir_rows[1]  = '{'{sct_pkg::REQ_ENTER, 17'sd0, 17'sd0, 16'sd0, 8'd0}, 1'b1,
                     '{1'b0, 1'b1, 16'd0, 5'd0, 1'b0, 16'sd0, 16'd0}};
    dir_rows[2]  = '{'{sct_pkg::REQ_EXIT, 17'sd0, 17'sd0, 16'sd0, 8'd0}, 1'b1,
                     '{1'b0, 1'b0, 16'd0, 5'd0, 1'b0, 16'sd0, 16'd0}};
    dir_rows[3]  = '{'{sct_pkg::REQ_SET, 17'sd0, 17'sd65535, 16'sd0, 8'd0}, 1'b1,
                     '{1'b0, 1'b1, 16'd4095, 5'd0, 1'b0, 16'sd0, 16'd0}};
    dir_rows[4]  = '{'{sct_pkg::REQ_SET, 17'sd0, 17'h10000, 16'sd0, 8'd0}, 1'b1,
                     '{1'b0, 1'b1, 16'd0, 5'd0, 1'b0, 16'sd0, 16'd0}};
    dir_rows[5]  = '{'{sct_pkg::REQ_JOG, 17'sd65535, 17'sd0, 16'sd0, 8'd0}, 1'b1,
                     '{1'b0, 1'b1, 16'd4095, 5'd0, 1'b0, 16'sd0, 16'd0}};
    dir_rows[6]  = '{'{sct_pkg::REQ_JOG, 17'h10000, 17'sd0, 16'sd0, 8'd0}, 1'b1,
                     '{1'b0, 1'b1, 16'd0, 5'd0, 1'b0, 16'sd0, 16'd0}};
    dir_rows[7]  = '{'{sct_pkg::REQ_JOG, 17'sd300, 17'sd0, 16'sd0, 8'd0}, 1'b0, '0};
    dir_rows[8]  = '{'{sct_pkg::REQ_ADD, 17'sd0, 17'sd0, 16'sh7fff, 8'd0}, 1'b0, '0};
    dir_rows[9]  = '{'{sct_pkg::REQ_ADD, 17'sd0, 17'sd0, 16'sh8000, 8'd0}, 1'b0, '0};
    dir_rows[10] = '{'{sct_pkg::REQ_JOG, 17'h1ffff, 17'sd0, 16'sd0, 8'd0}, 1'b0, '0};
    dir_rows[11] = '{'{sct_pkg::REQ_ADD, 17'sd0, 17'sd0, 16'sd0, 8'd0}, 1'b0, '0};
    dir_rows[12] = '{'{sct_pkg::REQ_ADD, 17'sd0, 17'sd0, 16'sh7fff, 8'd0}, 1'b0, '0};
    dir_rows[13] = '{'{sct_pkg::REQ_READ, 17'sd0, 17'sd0, 16'sd0, 8'd2}, 1'b0, '0};
    dir_rows[14] = '{'{sct_pkg::REQ_READ, 17'sd0, 17'sd0, 16'sd0, 8'd3}, 1'b1,
                     '{1'b0, 1'b1, 16'd299, 5'd3, 1'b0, 16'sd0, 16'd0}};
    dir_rows[15] = '{'{sct_pkg::REQ_READ, 17'sd0, 17'sd0, 16'sd0, 8'd255}, 1'b1,
                     '{1'b0, 1'b1, 16'd299, 5'd3, 1'b0, 16'sd0, 16'd0}};
    dir_rows[16] = '{'{sct_pkg::REQ_DELETE, 17'sd0, 17'sd0, 16'sd0, 8'd255}, 1'b0, '0};
    dir_rows[17] = '{'{sct_pkg::REQ_DELETE, 17'sd0, 17'sd0, 16'sd0, 8'd3}, 1'b0, '0};
    dir_rows[18] = '{'{sct_pkg::REQ_DELETE, 17'sd0, 17'sd0, 16'sd0, 8'd0}, 1'b0, '0};
    dir_rows[19] = '{'{sct_pkg::REQ_READ, 17'sd0, 17'sd0, 16'sd0, 8'd0}, 1'b0, '0};
    dir_rows[20] = '{'{sct_pkg::REQ_CLEAR, 17'sd0, 17'sd0, 16'sd0, 8'd0}, 1'b0, '0};
    dir_rows[21] = '{'{sct_pkg::REQ_READ, 17'sd0, 17'sd0, 16'sd0, 8'd0}, 1'b1,
                     '{1'b0, 1'b1, 16'd299, 5'd0, 1'b0, 16'sd0, 16'd0}};
    dir_rows[22] = '{'{sct_pkg::REQ_EXIT, 17'sd0, 17'sd0, 16'sd0, 8'd0}, 1'b0, '0};
    dir_rows[23] = '{'{sct_pkg::REQ_ADD, 17'sd0, 17'sd0, 16'shffff, 8'd0}, 1'b0, '0};
    dir_rows[24] = '{'{sct_pkg::REQ_READ, 17'sd0, 17'sd0, 16'sd0, 8'd0}, 1'b0, '0};

    // Hold reset, then release at a clock edge
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[k]) batch.push_back(dir_rows[k]);
    drive_batch();

    // Random phases, each under its own clamp and idling pattern
    for (int ph = 0; ph < 6; ph++) begin
      write_max_duty(caps[ph]);
      send_gaps = (ph == 0 || ph == 3 || ph == 5);
      take_gaps = (ph == 0 || ph == 1 || ph == 5);
      if (ph == 2) hold_out = 1'b1;
      plan_random(PHASE_ITEMS);
      drive_batch();
    end

    // Drain, then let the pipeline settle
    while (cal_results_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (err_count == 0 && cal_results_due.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
